@@ rtl/llca_pkg.sv @@
`timescale 1ns / 1ps

package llca_pkg;

	// Grid geometry.
	localparam int GRID_WIDTH  = 32;
	localparam int GRID_HEIGHT = 32;

	// Derived widths for row addresses and the generation step counter.
	localparam int ADDR_W    = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
	localparam int STEP_W    = $clog2(GRID_HEIGHT + 2);
	localparam int LAST_STEP = GRID_HEIGHT + 1;

	typedef logic [GRID_WIDTH-1:0] row_t;
	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [STEP_W-1:0]     step_t;

	// Rule thresholds held in the configuration registers.
	typedef struct packed {
		logic [3:0] death_low;
		logic [3:0] death_high;
		logic [3:0] birth_count;
	} rule_t;

	// Write request into the grid memory.
	typedef struct packed {
		logic  en;
		addr_t addr;
		row_t  data;
	} grid_wr_t;

	// Request modes.
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_GEN   = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_WRITTEN  = 2'd0;
	localparam logic [1:0] STAT_READ     = 2'd1;
	localparam logic [1:0] STAT_GEN_DONE = 2'd2;
	localparam logic [1:0] STAT_GEN_SKIP = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_DEATH_LOW   = 2'd0;
	localparam logic [1:0] CFG_DEATH_HIGH  = 2'd1;
	localparam logic [1:0] CFG_BIRTH_COUNT = 2'd2;

	// Rule values after reset.
	localparam logic [3:0] RST_DEATH_LOW   = 4'd1;
	localparam logic [3:0] RST_DEATH_HIGH  = 4'd4;
	localparam logic [3:0] RST_BIRTH_COUNT = 4'd3;

endpackage

@@ rtl/llca_lane.sv @@
`timescale 1ns / 1ps

module llca_lane (
	input  logic [2:0]     up,
	input  logic [2:0]     mid,
	input  logic [2:0]     lo,
	input  llca_pkg::rule_t rule,
	output logic           nxt
);
	import llca_pkg::*;

	logic [3:0] count;
	logic       alive;

	// Count the eight neighbors of the center cell.
	assign count = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(mid[0]) + 4'(mid[2])
		+ 4'(lo[0]) + 4'(lo[1]) + 4'(lo[2]);
	assign alive = mid[1];

	// Apply the survival and birth rules.
	always_comb begin
		if (alive) begin
			nxt = !((count <= rule.death_low) || (count >= rule.death_high));
		end else begin
			nxt = (count == rule.birth_count);
		end
	end

endmodule

@@ rtl/llca_row.sv @@
`timescale 1ns / 1ps

module llca_row (
	input  llca_pkg::row_t  up,
	input  llca_pkg::row_t  mid,
	input  llca_pkg::row_t  lo,
	input  llca_pkg::rule_t rule,
	output llca_pkg::row_t  nxt
);
	import llca_pkg::*;

	logic [GRID_WIDTH+1:0] up_pad;
	logic [GRID_WIDTH+1:0] mid_pad;
	logic [GRID_WIDTH+1:0] lo_pad;
	row_t                  lane_bits;

	// Columns outside the grid count as empty.
	assign up_pad  = {1'b0, up, 1'b0};
	assign mid_pad = {1'b0, mid, 1'b0};
	assign lo_pad  = {1'b0, lo, 1'b0};

	// One lane per column, each looking at its own three-by-three window.
	for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_lane
		llca_lane u_lane (
			.up   (up_pad[c+2:c]),
			.mid  (mid_pad[c+2:c]),
			.lo   (lo_pad[c+2:c]),
			.rule (rule),
			.nxt  (lane_bits[c])
		);
	end

	// Merge the lane results into the new row.
	assign nxt = lane_bits;

endmodule

@@ rtl/llca_grid.sv @@
`timescale 1ns / 1ps

module llca_grid (
	input  logic               clk,
	input  logic               arst_n,
	input  llca_pkg::grid_wr_t wr,
	input  logic               rd_en,
	input  llca_pkg::addr_t    rd_addr,
	output llca_pkg::row_t     rd_data
);
	import llca_pkg::*;

	row_t                   mem_q [GRID_HEIGHT];
	logic [GRID_HEIGHT-1:0] valid_q;
	row_t                   rd_q;

	// Per-row valid bits make the whole grid read as empty after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// Row storage with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= valid_q[rd_addr] ? mem_q[rd_addr] : '0;
		end
	end

	assign rd_data = rd_q;

endmodule

@@ rtl/life_like_cellular_automaton.sv @@
`timescale 1ns / 1ps

// Channel  Handshake                  Payload
// cfg      cfg_valid / cfg_ready      cfg_index, cfg_data
// in       in_valid  / in_ready       mode, row_index, row_bits
// out      out_valid / out_ready      row_out, status
//
// A row write ends in its request cycle; a row read uses the registered read port.
// A generation is taken in its request cycle and, if a live row has been written,
// then runs GRID_HEIGHT + 2 sweep steps in which rows stream one per cycle out of
// the single read port into a three-row window, and all column lanes form a new row
// each cycle, else it is skipped. Reset clears the grid through per-row valid bits.
// A stalled result holds in the output register and blocks the next request.
module life_like_cellular_automaton (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [4:0]  row_index,
	input  logic [31:0] row_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] row_out,
	output logic [1:0]  status
);
	import llca_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_GEN  = 2'd2;

	logic [1:0]  state_q;
	step_t       step_q;
	logic        out_valid_q;
	logic        any_written_q;
	rule_t       rule_q;
	logic [31:0] row_out_q;
	logic [1:0]  status_q;
	logic        hit_q;
	row_t        up_q;
	row_t        mid_q;

	logic        accept;
	logic        idx_ok;
	row_t        wr_row;
	logic        is_write;
	logic        is_read;
	logic        is_gen;
	logic        rd_en;
	addr_t       rd_addr;
	row_t        rd_data;
	row_t        lo_row;
	row_t        next_row;
	grid_wr_t    wr;
	logic        gen_wr;
	logic        gen_last;
	logic        out_set;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign idx_ok    = (32'(row_index) < 32'(GRID_HEIGHT));
	assign wr_row    = GRID_WIDTH'(row_bits);
	assign out_valid = out_valid_q;
	assign row_out   = row_out_q;
	assign status    = status_q;

	// Request decode; the spare mode acts as a read.
	always_comb begin
		is_write = 1'b0;
		is_read  = 1'b0;
		is_gen   = 1'b0;
		unique case (mode) inside
			MODE_WRITE:            is_write = 1'b1;
			MODE_GEN:              is_gen   = 1'b1;
			MODE_READ, MODE_SPARE: is_read  = 1'b1;
			default:               is_read  = 1'b1;
		endcase
	end

	// Generation sweep: step s reads row s and writes the new row s - 2.
	assign gen_last = (32'(step_q) == 32'(LAST_STEP));
	assign gen_wr   = (state_q == S_GEN) && (32'(step_q) >= 32'd2);
	assign lo_row   = ((step_q != '0) && (32'(step_q) <= 32'(GRID_HEIGHT))) ? rd_data : '0;

	assign rd_en   = ((state_q == S_GEN) && (32'(step_q) < 32'(GRID_HEIGHT)))
		|| (accept && is_read && idx_ok);
	assign rd_addr = (state_q == S_GEN) ? ADDR_W'(step_q) : ADDR_W'(row_index);

	// A result becomes ready when a request finishes in any of its paths.
	assign out_set = (accept && (is_write || (is_gen && !any_written_q)))
		|| (state_q == S_READ) || ((state_q == S_GEN) && gen_last);

	// Memory write request from either a generation or a row write.
	always_comb begin
		wr.en   = 1'b0;
		wr.addr = ADDR_W'(row_index);
		wr.data = wr_row;
		if (gen_wr) begin
			wr.en   = 1'b1;
			wr.addr = ADDR_W'(step_q - step_t'(2));
			wr.data = next_row;
		end else if (accept && is_write && idx_ok) begin
			wr.en = 1'b1;
		end
	end

	llca_grid u_grid (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	llca_row u_row (
		.up   (up_q),
		.mid  (mid_q),
		.lo   (lo_row),
		.rule (rule_q),
		.nxt  (next_row)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q.death_low   <= RST_DEATH_LOW;
			rule_q.death_high  <= RST_DEATH_HIGH;
			rule_q.birth_count <= RST_BIRTH_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEATH_LOW:   rule_q.death_low   <= cfg_data;
				CFG_DEATH_HIGH:  rule_q.death_high  <= cfg_data;
				CFG_BIRTH_COUNT: rule_q.birth_count <= cfg_data;
				default:         ;
			endcase
		end
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			step_q        <= '0;
			out_valid_q   <= 1'b0;
			any_written_q <= 1'b0;
		end else begin
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_write) begin
							if (idx_ok && (wr_row != '0)) begin
								any_written_q <= 1'b1;
							end
						end else if (is_gen) begin
							if (any_written_q) begin
								state_q <= S_GEN;
								step_q  <= '0;
							end
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				S_GEN: begin
					if (gen_last) begin
						state_q <= S_IDLE;
					end else begin
						step_q <= step_q + step_t'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result payload and the three-row window.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			row_out_q <= '0;
			hit_q     <= idx_ok;
			if (is_write) begin
				status_q <= STAT_WRITTEN;
			end else if (is_gen) begin
				status_q <= any_written_q ? STAT_GEN_DONE : STAT_GEN_SKIP;
			end else begin
				status_q <= STAT_READ;
			end
		end else if (state_q == S_READ) begin
			row_out_q <= hit_q ? 32'(rd_data) : '0;
		end
		if (state_q == S_GEN) begin
			if (step_q == '0) begin
				up_q  <= '0;
				mid_q <= '0;
			end else begin
				up_q  <= mid_q;
				mid_q <= lo_row;
			end
		end
	end

	// New rows are written back only during a generation or a row write.
	a_wr_source: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == S_GEN) || (accept && is_write))
		else $error("grid write outside a generation or row write");

	// A generation only runs once a live row has been written.
	a_gen_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GEN) |-> any_written_q)
		else $error("generation running before any live row was written");

	// The sweep advances one row per cycle until its last step.
	a_step_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GEN) && !gen_last |=> (step_q == $past(step_q) + step_t'(1)))
		else $error("generation step counter skipped");

	// No request is taken while a read or generation is in flight.
	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("request accepted while busy");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import llca_pkg::*;

	// Cycles without any handshake before the run is declared hung.
	localparam int STALL_LIMIT     = 4000;
	// Length of the deliberate output hold-off in the back-pressure test.
	localparam int HOLD_OFF_CYCLES = 300;
	// Least number of requests per rule setting in the random phases.
	localparam int PHASE_REQUESTS  = 215;

	typedef struct packed {
		row_t       row_out;
		logic [1:0] status;
	} life_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_DEATH_LOW;
	logic [3:0]  cfg_data = 4'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = MODE_WRITE;
	logic [4:0]  row_index = 5'd0;
	logic [31:0] row_bits = 32'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] row_out;
	logic [1:0]  status;

	// Shadow copy of the grid and the rule registers.
	row_t  life_grid [GRID_HEIGHT];
	bit    grid_seeded = 1'b0;
	rule_t rules = '{RST_DEATH_LOW, RST_DEATH_HIGH, RST_BIRTH_COUNT};

	life_result_t pending_results [$];

	int  error_count = 0;
	int  requests_sent = 0;
	int  rows_written = 0;
	int  rows_read = 0;
	int  gens_advanced = 0;
	int  gens_skipped = 0;
	int  rule_writes = 0;
	int  rule_settings = 0;
	int  quiet_cycles = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	bit  hold_off_request = 1'b0;
	bit  calm = 1'b0;

	life_like_cellular_automaton dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.row_index (row_index),
		.row_bits  (row_bits),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.row_out   (row_out),
		.status    (status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		foreach (life_grid[r]) life_grid[r] = '0;
	end

	// Mostly back-to-back, sometimes a short pause, now and then a long one.
	function automatic int idle_gap();
		int pick;
		if (calm) return 0;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Random row content with varying density.
	function automatic logic [31:0] random_row();
		case ($urandom_range(0, 4))
			0: return $urandom & $urandom & $urandom;
			1: return $urandom | $urandom;
			2: return 32'h7 << $urandom_range(0, 29);
			3: return ($urandom_range(0, 3) == 0) ? 32'd0 : 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// A cell outside the grid counts as empty.
	function automatic bit cell_live(int r, int c);
		if (r < 0 || r >= GRID_HEIGHT || c < 0 || c >= GRID_WIDTH) return 1'b0;
		return life_grid[r][c];
	endfunction

	// Compute one synchronous generation of the shadow grid.
	function automatic void step_generation();
		row_t next_grid [GRID_HEIGHT];
		int   neighbors;
		for (int r = 0; r < GRID_HEIGHT; r++) begin
			next_grid[r] = '0;
			for (int c = 0; c < GRID_WIDTH; c++) begin
				neighbors = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						if (dr != 0 || dc != 0) neighbors += cell_live(r + dr, c + dc);
					end
				end
				if (life_grid[r][c]) begin
					next_grid[r][c] = !(neighbors <= int'(rules.death_low) ||
						neighbors >= int'(rules.death_high));
				end else begin
					next_grid[r][c] = (neighbors == int'(rules.birth_count));
				end
			end
		end
		life_grid = next_grid;
	endfunction

	// Update the shadow state for one accepted request and return its result.
	function automatic life_result_t apply_request(logic [1:0] req_mode, logic [4:0] req_row,
			logic [31:0] req_bits);
		life_result_t res;
		res.row_out = '0;
		case (req_mode)
			MODE_WRITE: begin
				if (int'(req_row) < GRID_HEIGHT) begin
					life_grid[req_row] = req_bits;
					if (req_bits != 0) grid_seeded = 1'b1;
				end
				res.status = STAT_WRITTEN;
				rows_written++;
			end
			MODE_GEN: begin
				if (grid_seeded) begin
					step_generation();
					res.status = STAT_GEN_DONE;
					gens_advanced++;
				end else begin
					res.status = STAT_GEN_SKIP;
					gens_skipped++;
				end
			end
			default: begin
				// The spare mode reads a row just like the read mode.
				if (int'(req_row) < GRID_HEIGHT) res.row_out = life_grid[req_row];
				res.status = STAT_READ;
				rows_read++;
			end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ERROR: %s", $realtime, msg);
		error_count++;
	endtask

	// Offer one request after a random gap and predict it once accepted.
	// Valid stays high on return so back-to-back requests never toggle it.
	task automatic send_request(input logic [1:0] req_mode, input logic [4:0] req_row,
			input logic [31:0] req_bits);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= req_mode;
		row_index <= req_row;
		row_bits  <= req_bits;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.insert(pending_results.size(),
			apply_request(req_mode, req_row, req_bits));
		requests_sent++;
	endtask

	// Drop the request line and wait until every result has come back.
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_rule(input logic [1:0] reg_index, input logic [3:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= reg_index;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (reg_index)
			CFG_DEATH_LOW:  rules.death_low = value;
			CFG_DEATH_HIGH: rules.death_high = value;
			default:        rules.birth_count = value;
		endcase
		rule_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Generations and an empty grid before any live cell has been written.
	task automatic test_generation_skipped();
		send_request(MODE_GEN, 5'd0, 32'd0);
		send_request(MODE_WRITE, 5'd5, 32'd0);
		send_request(MODE_GEN, 5'd9, 32'hFFFF_FFFF);
		send_request(MODE_READ, 5'd0, 32'd0);
		send_request(MODE_SPARE, 5'd31, 32'hFFFF_FFFF);
		wait_for_idle();
	endtask

	// A full top row, corner cells on the bottom row, a blinker, and a grid that dies out.
	task automatic test_edge_patterns();
		send_request(MODE_WRITE, 5'd0, 32'hFFFF_FFFF);
		send_request(MODE_WRITE, 5'd31, 32'h8000_0001);
		send_request(MODE_WRITE, 5'd16, 32'h0000_0380);
		send_request(MODE_READ, 5'd0, 32'd0);
		send_request(MODE_SPARE, 5'd31, 32'd0);
		send_request(MODE_GEN, 5'd0, 32'd0);
		send_request(MODE_READ, 5'd16, 32'd0);
		send_request(MODE_READ, 5'd15, 32'd0);
		send_request(MODE_GEN, 5'd0, 32'd0);
		send_request(MODE_READ, 5'd16, 32'd0);
		send_request(MODE_WRITE, 5'd0, 32'd0);
		send_request(MODE_WRITE, 5'd31, 32'd0);
		send_request(MODE_WRITE, 5'd16, 32'd0);
		send_request(MODE_WRITE, 5'd10, 32'h0000_0001);
		// A lone cell dies; the grid stays marked as seeded afterwards.
		send_request(MODE_GEN, 5'd0, 32'd0);
		send_request(MODE_GEN, 5'd0, 32'd0);
		send_request(MODE_READ, 5'd10, 32'd0);
		wait_for_idle();
	endtask

	// Mostly seed-then-evolve sequences, with some fully random requests.
	task automatic run_random_requests(input int count);
		int sent;
		int ops;
		int pick;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) < 7) begin
				ops = $urandom_range(1, 6);
				repeat (ops) begin
					send_request(MODE_WRITE, 5'($urandom_range(0, 31)), random_row());
					sent++;
				end
				ops = $urandom_range(1, 5);
				repeat (ops) begin
					pick = $urandom_range(0, 9);
					if (pick < 5) send_request(MODE_GEN, 5'($urandom), $urandom);
					else if (pick < 8) send_request(MODE_READ, 5'($urandom), $urandom);
					else send_request(MODE_SPARE, 5'($urandom), $urandom);
					sent++;
				end
			end else begin
				send_request(2'($urandom_range(0, 3)), 5'($urandom), random_row());
				sent++;
			end
		end
	endtask

	// Step through rule settings, extremes included, with random traffic each.
	task automatic test_rule_phases();
		rule_t phase_rules [7];
		phase_rules[0] = '{RST_DEATH_LOW, RST_DEATH_HIGH, RST_BIRTH_COUNT};
		phase_rules[1] = '{4'd0, 4'd9, 4'd0};
		phase_rules[2] = '{4'd15, 4'd15, 4'd15};
		phase_rules[3] = '{4'd0, 4'd15, 4'd8};
		phase_rules[4] = '{4'd2, 4'd3, 4'd2};
		phase_rules[5] = '{4'd8, 4'd0, 4'd6};
		phase_rules[6] = '{4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
			4'($urandom_range(0, 15))};
		for (int p = 0; p < 7; p++) begin
			wait_for_idle();
			write_rule(CFG_DEATH_LOW, phase_rules[p].death_low);
			write_rule(CFG_DEATH_HIGH, phase_rules[p].death_high);
			write_rule(CFG_BIRTH_COUNT, phase_rules[p].birth_count);
			rule_settings++;
			// One phase runs without any idle cycles on either side.
			calm = (p == 2);
			run_random_requests(PHASE_REQUESTS);
			calm = 1'b0;
		end
		wait_for_idle();
	endtask

	// Hold the result side off long enough for the input to stall.
	task automatic test_output_backpressure();
		hold_off_request = 1'b1;
		repeat (16) send_request(2'($urandom_range(0, 3)), 5'($urandom), random_row());
		wait_for_idle();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_generation_skipped();
		test_edge_patterns();
		test_output_backpressure();
		test_rule_phases();
		repeat (GRID_HEIGHT + 4) @(posedge clk);
		$display("Sent %0d requests: %0d row writes, %0d row reads, %0d generations, %0d skipped.",
			requests_sent, rows_written, rows_read, gens_advanced, gens_skipped);
		$display("Rules set %0d times in %0d writes, with output hold-off and gap-free stretches.",
			rule_settings, rule_writes);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Result side readiness: random stalls plus the requested long hold-off.
	always @(posedge clk) begin
		if (hold_off_request) begin
			hold_left = HOLD_OFF_CYCLES;
			hold_off_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!calm && $urandom_range(0, 5) == 0) stall_left = idle_gap();
		end
	end

	// Compare each delivered result with the oldest prediction.
	always @(posedge clk) begin
		life_result_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with no request pending: row_out %h status %0d",
					row_out, status));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status got %0d expected %0d", status, want.status));
				if (row_out !== want.row_out)
					report_mismatch($sformatf("row_out got %h expected %h (status %0d)",
						row_out, want.row_out, want.status));
			end
		end
	end

	// End the run if no channel moves anything for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles == STALL_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles.", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule

@@ filelist.f @@
rtl/llca_pkg.sv
rtl/llca_lane.sv
rtl/llca_row.sv
rtl/llca_grid.sv
rtl/life_like_cellular_automaton.sv
tb/sv/tb_top.sv
